>>> design/pattern_chain_step_sequencer_top_assert.svh
// assertion macros shared by the sequencer modules
`ifndef PATTERN_CHAIN_STEP_SEQUENCER_TOP_ASSERT_SVH
`define PATTERN_CHAIN_STEP_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PCS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcs assertion failed");
`define PCS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcs assertion failed");
`else
`define PCS_ASSERT_IMP(name, ante, cons)
`define PCS_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> design/pcs_pkg.sv
package pcs_pkg;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_CHAIN     = 3'd1;
  localparam logic [2:0] OP_UNCHAIN   = 3'd2;
  localparam logic [2:0] OP_CLR_CHAIN = 3'd3;
  localparam logic [2:0] OP_WRITE     = 3'd4;
  localparam logic [2:0] OP_CLR_EDIT  = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] pattern_number;
    logic [3:0] step_number;
    logic       step_enable;
    logic [2:0] scale_degree;
    logic       accent_flag;
    logic       slide_flag;
  } pcs_in_t;

  typedef struct packed {
    logic [3:0]  step_position;
    logic [2:0]  playing_pattern;
    logic [3:0]  chain_count;
    logic [2:0]  chain_slot;
    logic [31:0] tick_total;
    logic        note_on;
    logic [2:0]  note_degree;
    logic        note_accent;
    logic        note_slide;
    logic        took_effect;
  } pcs_out_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_FIX,
    ST_WIPE_EDIT,
    ST_READ,
    ST_RESP
  } pcs_state_t;

  typedef struct packed {
    logic load;
    logic wipe;
    logic tick;
    logic chain;
    logic unchain_start;
    logic shift;
    logic unchain_fix;
    logic clear_chain;
    logic write_step;
    logic edit_start;
    logic wipe_edit;
    logic read;
  } pcs_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       took;
    logic       wipe_last;
    logic       edit_last;
    logic       shift_last;
  } pcs_stat_t;

endpackage

>>> design/pattern_chain_step_sequencer_top.sv
// Step sequencer with a pattern store and an ordered pattern chain. An item is taken
// when start is high and busy is low; its one result appears on result for a single
// cycle with done high, and the receiver cannot stall it. Tick, chain, clear chain,
// write step, unused opcodes and an unchain that finds nothing go from accept through
// execute, read and response; an unchain that removes a pattern adds a shift walking
// chain entries from the tail down to the removed one (at most PATTERNS) and a fix
// step; clear edit pattern adds a wipe of STEPS entries, one store entry per cycle
// through the single write port. After reset the step store is cleared one entry a
// cycle, PATTERNS rounded up to a power of two times STEPS rounded up likewise (128
// entries at the defaults), with busy high; configuration writes are always ready.
module pattern_chain_step_sequencer_top #(
  parameter int STEPS    = 16,
  parameter int PATTERNS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcs_pkg::pcs_in_t  item,
  output logic              done,
  output pcs_pkg::pcs_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data
);

  pcs_pkg::pcs_cmd_t  cmd;
  pcs_pkg::pcs_stat_t stat;

  assign cfg_ready = 1'b1;

  pcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pcs_dp #(
    .STEPS    (STEPS),
    .PATTERNS (PATTERNS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule

>>> design/pcs_ctrl.sv
`include "pattern_chain_step_sequencer_top_assert.svh"

module pcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pcs_pkg::pcs_stat_t  stat,
  output pcs_pkg::pcs_cmd_t   cmd,
  output logic                busy,
  output logic                done
);

  pcs_pkg::pcs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcs_pkg::ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcs_pkg::ST_WIPE: begin
        if (stat.wipe_last) begin
          state_next = pcs_pkg::ST_IDLE;
        end
      end
      pcs_pkg::ST_IDLE: begin
        if (start) begin
          state_next = pcs_pkg::ST_EXEC;
        end
      end
      pcs_pkg::ST_EXEC: begin
        case (stat.opcode)
          pcs_pkg::OP_UNCHAIN: begin
            state_next = stat.took ? pcs_pkg::ST_SHIFT : pcs_pkg::ST_READ;
          end
          pcs_pkg::OP_CLR_EDIT: begin
            state_next = pcs_pkg::ST_WIPE_EDIT;
          end
          default: begin
            state_next = pcs_pkg::ST_READ;
          end
        endcase
      end
      pcs_pkg::ST_SHIFT: begin
        if (stat.shift_last) begin
          state_next = pcs_pkg::ST_FIX;
        end
      end
      pcs_pkg::ST_FIX: begin
        state_next = pcs_pkg::ST_READ;
      end
      pcs_pkg::ST_WIPE_EDIT: begin
        if (stat.edit_last) begin
          state_next = pcs_pkg::ST_READ;
        end
      end
      pcs_pkg::ST_READ: begin
        state_next = pcs_pkg::ST_RESP;
      end
      pcs_pkg::ST_RESP: begin
        state_next = pcs_pkg::ST_IDLE;
      end
      default: begin
        state_next = pcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      pcs_pkg::ST_WIPE: begin
        cmd.wipe = 1'b1;
      end
      pcs_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      pcs_pkg::ST_EXEC: begin
        case (stat.opcode)
          pcs_pkg::OP_TICK:      cmd.tick          = 1'b1;
          pcs_pkg::OP_CHAIN:     cmd.chain         = stat.took;
          pcs_pkg::OP_UNCHAIN:   cmd.unchain_start = stat.took;
          pcs_pkg::OP_CLR_CHAIN: cmd.clear_chain   = 1'b1;
          pcs_pkg::OP_WRITE:     cmd.write_step    = 1'b1;
          pcs_pkg::OP_CLR_EDIT:  cmd.edit_start    = 1'b1;
          default: begin
            cmd = '0;
          end
        endcase
      end
      pcs_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
      end
      pcs_pkg::ST_FIX: begin
        cmd.unchain_fix = 1'b1;
      end
      pcs_pkg::ST_WIPE_EDIT: begin
        cmd.wipe_edit = 1'b1;
      end
      pcs_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      pcs_pkg::ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PCS_ASSERT_NXT(a_accept_exec, start && !busy, state == pcs_pkg::ST_EXEC)
  `PCS_ASSERT_NXT(a_shift_fix, (state == pcs_pkg::ST_SHIFT) && stat.shift_last, state == pcs_pkg::ST_FIX)
  `PCS_ASSERT_IMP(a_cmd_single, 1'b1, $onehot0(cmd))

endmodule

>>> design/pcs_dp.sv
`include "pattern_chain_step_sequencer_top_assert.svh"

module pcs_dp #(
  parameter int STEPS    = 16,
  parameter int PATTERNS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  pcs_pkg::pcs_in_t   item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  input  pcs_pkg::pcs_cmd_t  cmd,
  output pcs_pkg::pcs_stat_t stat,
  output pcs_pkg::pcs_out_t  result
);

  localparam int SW    = $clog2(STEPS);
  localparam int PW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int LW    = $clog2(PATTERNS + 1);
  localparam int AW    = PW + SW;
  localparam int DEPTH = 1 << AW;
  localparam logic [5:0] PAT_LIM  = 6'(PATTERNS);
  localparam logic [6:0] STEP_LIM = 7'(STEPS);

  typedef struct packed {
    logic       on;
    logic [2:0] degree;
    logic       accent;
    logic       slide;
  } step_t;

  pcs_pkg::pcs_in_t item_r;
  logic             took;
  logic             took_next;
  logic [PW-1:0]    edit;
  logic [SW-1:0]    step_pos;
  logic [31:0]      tick_count;
  logic [PW-1:0]    play;
  logic [LW-1:0]    len;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    list [PATTERNS];
  logic [PATTERNS-1:0] mark;
  logic [PW-1:0]    carry;
  logic [AW-1:0]    cnt;
  step_t            mem [DEPTH];
  step_t            rd_data;

  logic [PW-1:0] pidx;
  logic          pn_ok;
  logic          sn_ok;
  logic [LW-1:0] pos_inc;
  logic [PW-1:0] tick_pos;
  logic [LW-1:0] len_dec;
  logic [PW-1:0] fix_pos;
  logic [PW-1:0] rd_idx;
  logic [PW-1:0] list_q;
  logic          step_wrap;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  step_t         mem_wdata;

  // decode of the incoming item against the current chain
  always_comb begin
    pidx  = PW'(item.pattern_number);
    pn_ok = 6'(item.pattern_number) < PAT_LIM;
    case (item.opcode)
      pcs_pkg::OP_TICK, pcs_pkg::OP_CLR_CHAIN, pcs_pkg::OP_WRITE, pcs_pkg::OP_CLR_EDIT: begin
        took_next = 1'b1;
      end
      pcs_pkg::OP_CHAIN: begin
        took_next = pn_ok && !mark[pidx] && (len < LW'(PATTERNS));
      end
      pcs_pkg::OP_UNCHAIN: begin
        took_next = pn_ok && mark[pidx];
      end
      default: begin
        took_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_inc   = LW'(pos) + LW'(1);
    tick_pos  = (pos_inc == len) ? '0 : PW'(pos_inc);
    len_dec   = len - LW'(1);
    fix_pos   = (LW'(pos) >= len_dec) ? '0 : pos;
    step_wrap = step_pos == SW'(STEPS - 1);
    sn_ok     = 7'(item_r.step_number) < STEP_LIM;
    // single read port on the chain list
    if (cmd.shift) begin
      rd_idx = PW'(cnt);
    end else if (cmd.unchain_fix) begin
      rd_idx = fix_pos;
    end else begin
      rd_idx = tick_pos;
    end
    list_q = list[rd_idx];
  end

  always_comb begin
    stat.opcode     = item_r.opcode;
    stat.took       = took;
    stat.wipe_last  = &cnt;
    stat.edit_last  = cnt[SW-1:0] == SW'(STEPS - 1);
    stat.shift_last = (list_q == PW'(item_r.pattern_number)) || (cnt[PW-1:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.wipe || cmd.wipe_edit) begin
      cnt <= cnt + AW'(1);
    end else if (cmd.edit_start) begin
      cnt <= '0;
    end else if (cmd.unchain_start) begin
      cnt <= AW'(len_dec);
    end else if (cmd.shift) begin
      cnt <= cnt - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit       <= '0;
      step_pos   <= '0;
      tick_count <= '0;
      play       <= '0;
      len        <= '0;
      pos        <= '0;
      mark       <= '0;
    end else begin
      if (cfg_we && (6'(cfg_data) < PAT_LIM)) begin
        edit <= PW'(cfg_data);
      end
      if (cmd.tick) begin
        tick_count <= tick_count + 32'd1;
        step_pos   <= step_wrap ? '0 : step_pos + SW'(1);
        if (step_wrap && (len > LW'(1))) begin
          pos  <= tick_pos;
          play <= list_q;
        end
      end
      if (cmd.chain) begin
        mark[PW'(item_r.pattern_number)] <= 1'b1;
        len <= len + LW'(1);
        if (len == '0) begin
          play <= PW'(item_r.pattern_number);
          pos  <= '0;
        end
      end
      if (cmd.unchain_start) begin
        mark[PW'(item_r.pattern_number)] <= 1'b0;
      end
      if (cmd.unchain_fix) begin
        len  <= len_dec;
        pos  <= fix_pos;
        play <= (len_dec != '0) ? list_q : edit;
      end
      if (cmd.clear_chain) begin
        mark <= '0;
        len  <= '0;
        pos  <= '0;
        play <= edit;
      end
      if (cmd.edit_start) begin
        step_pos <= '0;
      end
    end
  end

  // item capture and chain list; the shift walks down from the tail carrying entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
      took   <= took_next;
    end
    if (cmd.chain) begin
      list[PW'(len)] <= PW'(item_r.pattern_number);
    end
    if (cmd.shift) begin
      list[PW'(cnt)] <= carry;
      carry          <= list_q;
    end
  end

  always_comb begin
    mem_we    = cmd.wipe || cmd.wipe_edit || (cmd.write_step && sn_ok);
    mem_wdata = '0;
    if (cmd.wipe) begin
      mem_waddr = cnt;
    end else if (cmd.wipe_edit) begin
      mem_waddr = {edit, cnt[SW-1:0]};
    end else begin
      mem_waddr        = {edit, SW'(item_r.step_number)};
      mem_wdata.on     = item_r.step_enable;
      mem_wdata.degree = item_r.scale_degree;
      mem_wdata.accent = item_r.accent_flag;
      mem_wdata.slide  = item_r.slide_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= mem[{play, step_pos}];
    end
  end

  always_comb begin
    result.step_position   = 4'(step_pos);
    result.playing_pattern = 3'(play);
    result.chain_count     = 4'(len);
    result.chain_slot      = 3'(pos);
    result.tick_total      = tick_count;
    result.note_on         = rd_data.on;
    result.note_degree     = rd_data.degree;
    result.note_accent     = rd_data.accent;
    result.note_slide      = rd_data.slide;
    result.took_effect     = took;
  end

  `PCS_ASSERT_IMP(a_len_max, 1'b1, len <= LW'(PATTERNS))
  `PCS_ASSERT_IMP(a_pos_range, len != '0, LW'(pos) < len)
  `PCS_ASSERT_IMP(a_pos_empty, len == '0, pos == '0)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // opcodes the block does not decode
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int N_PATTERNS = 8;
  localparam int N_STEPS    = 16;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 100;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         cfg_val;
    pcs_pkg::pcs_in_t   cmd;
    logic [5:0]         reps;
    logic               typed;
    pcs_pkg::pcs_out_t  want;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  pcs_pkg::pcs_in_t  item;
  logic              done;
  pcs_pkg::pcs_out_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_data;

  pattern_chain_step_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // sequencer state as the block should hold it
  logic [2:0]  edit_sel;
  logic [3:0]  cur_step;
  logic [31:0] ticks;
  logic [2:0]  now_playing;
  logic [3:0]  link_count;
  logic [2:0]  link_slot;
  logic [2:0]  link_order [N_PATTERNS];
  logic        linked [N_PATTERNS];
  logic [5:0]  pattern_mem [N_PATTERNS * N_STEPS];

  pcs_pkg::pcs_out_t pending_status [$];
  plan_row_t         plan [$];
  int                mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic pcs_pkg::pcs_out_t advance_sequencer(pcs_pkg::pcs_in_t cmd);
    pcs_pkg::pcs_out_t r;
    logic [5:0]        cur;
    logic              took;
    int                at;
    took = 1'b1;
    case (cmd.opcode)
      pcs_pkg::OP_TICK: begin
        ticks = ticks + 32'd1;
        cur_step = cur_step + 4'd1;
        if (cur_step == 4'd0 && link_count > 4'd1) begin
          link_slot = 3'((int'(link_slot) + 1) % int'(link_count));
          now_playing = link_order[link_slot];
        end
      end
      pcs_pkg::OP_CHAIN: begin
        if (linked[cmd.pattern_number] || link_count >= 4'(N_PATTERNS)) begin
          took = 1'b0;
        end else begin
          linked[cmd.pattern_number] = 1'b1;
          link_order[link_count[2:0]] = cmd.pattern_number;
          link_count = link_count + 4'd1;
          if (link_count == 4'd1) begin
            now_playing = cmd.pattern_number;
            link_slot = 3'd0;
          end
        end
      end
      pcs_pkg::OP_UNCHAIN: begin
        if (!linked[cmd.pattern_number]) begin
          took = 1'b0;
        end else begin
          linked[cmd.pattern_number] = 1'b0;
          at = -1;
          for (int i = 0; i < N_PATTERNS; i++)
            if (at < 0 && i < int'(link_count) && link_order[i] == cmd.pattern_number)
              at = i;
          if (at >= 0) begin
            // close the gap left by the removed entry
            for (int i = 0; i < N_PATTERNS - 1; i++)
              if (i >= at && i + 1 < int'(link_count))
                link_order[i] = link_order[i + 1];
            link_count = link_count - 4'd1;
            if ({1'b0, link_slot} >= link_count)
              link_slot = 3'd0;
            now_playing = (link_count > 4'd0) ? link_order[link_slot] : edit_sel;
          end
        end
      end
      pcs_pkg::OP_CLR_CHAIN: begin
        for (int i = 0; i < N_PATTERNS; i++)
          linked[i] = 1'b0;
        link_count = 4'd0;
        link_slot = 3'd0;
        now_playing = edit_sel;
      end
      pcs_pkg::OP_WRITE: begin
        pattern_mem[{edit_sel, cmd.step_number}] =
          {cmd.step_enable, cmd.scale_degree, cmd.accent_flag, cmd.slide_flag};
      end
      pcs_pkg::OP_CLR_EDIT: begin
        for (int i = 0; i < N_STEPS; i++)
          pattern_mem[{edit_sel, 4'(i)}] = 6'd0;
        cur_step = 4'd0;
      end
      default: begin
        took = 1'b0;
      end
    endcase
    cur = pattern_mem[{now_playing, cur_step}];
    r.step_position   = cur_step;
    r.playing_pattern = now_playing;
    r.chain_count     = link_count;
    r.chain_slot      = link_slot;
    r.tick_total      = ticks;
    r.note_on         = cur[5];
    r.note_degree     = cur[4:2];
    r.note_accent     = cur[1];
    r.note_slide      = cur[0];
    r.took_effect     = took;
    return r;
  endfunction

  function automatic pcs_pkg::pcs_in_t mk_cmd(logic [2:0] op, logic [2:0] pn, logic [3:0] sn,
                                              logic en, logic [2:0] deg, logic acc,
                                              logic sld);
    pcs_pkg::pcs_in_t c;
    c.opcode         = op;
    c.pattern_number = pn;
    c.step_number    = sn;
    c.step_enable    = en;
    c.scale_degree   = deg;
    c.accent_flag    = acc;
    c.slide_flag     = sld;
    return c;
  endfunction

  function automatic pcs_pkg::pcs_out_t mk_status(logic [3:0] pos, logic [2:0] play,
                                                  logic [3:0] cnt, logic [2:0] slot,
                                                  logic [31:0] tk, logic on,
                                                  logic [2:0] deg, logic acc, logic sld,
                                                  logic took);
    pcs_pkg::pcs_out_t s;
    s.step_position   = pos;
    s.playing_pattern = play;
    s.chain_count     = cnt;
    s.chain_slot      = slot;
    s.tick_total      = tk;
    s.note_on         = on;
    s.note_degree     = deg;
    s.note_accent     = acc;
    s.note_slide      = sld;
    s.took_effect     = took;
    return s;
  endfunction

  function automatic void add_row(row_kind_t kind, logic [2:0] cfg_val,
                                  pcs_pkg::pcs_in_t cmd, int reps, logic typed,
                                  pcs_pkg::pcs_out_t want);
    plan_row_t r;
    r.kind    = kind;
    r.cfg_val = cfg_val;
    r.cmd     = cmd;
    r.reps    = 6'(reps);
    r.typed   = typed;
    r.want    = want;
    plan.push_back(r);
  endfunction

  function automatic pcs_pkg::pcs_in_t random_cmd();
    pcs_pkg::pcs_in_t c;
    int               r;
    c = mk_cmd(3'd0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (r < 45)      c.opcode = pcs_pkg::OP_TICK;
    else if (r < 62) c.opcode = pcs_pkg::OP_CHAIN;
    else if (r < 76) c.opcode = pcs_pkg::OP_UNCHAIN;
    else if (r < 90) c.opcode = pcs_pkg::OP_WRITE;
    else if (r < 93) c.opcode = pcs_pkg::OP_CLR_CHAIN;
    else if (r < 96) c.opcode = pcs_pkg::OP_CLR_EDIT;
    else             c.opcode = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    return c;
  endfunction

  // one command transfer; start stays high so back-to-back commands need no gap
  task automatic issue(pcs_pkg::pcs_in_t cmd, logic typed, pcs_pkg::pcs_out_t want);
    pcs_pkg::pcs_out_t pred;
    item  <= cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pred = advance_sequencer(cmd);
    pending_status.push_back(typed ? want : pred);
  endtask

  task automatic sender_gap(bit quiet);
    int r;
    int n;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r < 55)      n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else             n = $urandom_range(10, 40);
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  // edit pattern only changes with nothing in flight
  task automatic write_edit_pattern(logic [2:0] val);
    start <= 1'b0;
    while (pending_status.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    edit_sel = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic field_check(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h got %0h", $realtime, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pcs_pkg::pcs_out_t exp_s;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result %h", $realtime, result);
      end else begin
        exp_s = pending_status.pop_front();
        field_check("step_position",   32'(exp_s.step_position),   32'(result.step_position));
        field_check("playing_pattern", 32'(exp_s.playing_pattern), 32'(result.playing_pattern));
        field_check("chain_count",     32'(exp_s.chain_count),     32'(result.chain_count));
        field_check("chain_slot",      32'(exp_s.chain_slot),      32'(result.chain_slot));
        field_check("tick_total",      exp_s.tick_total,           result.tick_total);
        field_check("note_on",         32'(exp_s.note_on),         32'(result.note_on));
        field_check("note_degree",     32'(exp_s.note_degree),     32'(result.note_degree));
        field_check("note_accent",     32'(exp_s.note_accent),     32'(result.note_accent));
        field_check("note_slide",      32'(exp_s.note_slide),      32'(result.note_slide));
        field_check("took_effect",     32'(exp_s.took_effect),     32'(result.took_effect));
      end
    end
  end

  initial begin
    pcs_pkg::pcs_out_t none;
    plan_row_t         row;
    pcs_pkg::pcs_in_t  cmd;
    int                sent;
    int                burst;
    bit                quiet;

    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = 3'd0;
    mismatches = 0;
    none = '0;

    edit_sel    = 3'd0;
    cur_step    = 4'd0;
    ticks       = 32'd0;
    now_playing = 3'd0;
    link_count  = 4'd0;
    link_slot   = 3'd0;
    for (int i = 0; i < N_PATTERNS; i++) begin
      link_order[i] = 3'd0;
      linked[i]     = 1'b0;
    end
    for (int i = 0; i < N_PATTERNS * N_STEPS; i++)
      pattern_mem[i] = 6'd0;

    // directed part: fresh state, no-ops, store writes, chain walk and repair
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_TICK, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b1,
            mk_status(4'd1, 3'd0, 4'd0, 3'd0, 32'd1, 1'b0, 3'd0, 1'b0, 1'b0, 1'b1));
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(OP_SPARE_HI, 3'd7, 4'd15, 1'b1, 3'd7, 1'b1, 1'b1), 1, 1'b1,
            mk_status(4'd1, 3'd0, 4'd0, 3'd0, 32'd1, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0));
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(OP_SPARE_LO, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b1,
            mk_status(4'd1, 3'd0, 4'd0, 3'd0, 32'd1, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0));
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_UNCHAIN, 3'd3, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b1,
            mk_status(4'd1, 3'd0, 4'd0, 3'd0, 32'd1, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0));
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_WRITE, 3'd0, 4'd2, 1'b1, 3'd7, 1'b1, 1'b1), 1, 1'b1,
            mk_status(4'd1, 3'd0, 4'd0, 3'd0, 32'd1, 1'b0, 3'd0, 1'b0, 1'b0, 1'b1));
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_WRITE, 3'd0, 4'd1, 1'b1, 3'd5, 1'b0, 1'b1), 1, 1'b1,
            mk_status(4'd1, 3'd0, 4'd0, 3'd0, 32'd1, 1'b1, 3'd5, 1'b0, 1'b1, 1'b1));
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_TICK, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b1,
            mk_status(4'd2, 3'd0, 4'd0, 3'd0, 32'd2, 1'b1, 3'd7, 1'b1, 1'b1, 1'b1));
    add_row(ROW_CFG,  3'd7, none, 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_WRITE, 3'd5, 4'd0, 1'b1, 3'd3, 1'b1, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_WRITE, 3'd0, 4'd15, 1'b1, 3'd7, 1'b1, 1'b1), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CHAIN, 3'd7, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CHAIN, 3'd7, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CHAIN, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CHAIN, 3'd3, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CHAIN, 3'd1, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_CFG,  3'd5, none, 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CLR_EDIT, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    // walk to the last step, then wrap twice so the slot sits past the head
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_TICK, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 15, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_TICK, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 17, 1'b0, none);
    // removal ahead of the slot leaves the slot index alone
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_UNCHAIN, 3'd7, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_UNCHAIN, 3'd1, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_UNCHAIN, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_UNCHAIN, 3'd3, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CHAIN, 3'd2, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CLR_CHAIN, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);
    add_row(ROW_CFG,  3'd0, none, 1, 1'b0, none);
    add_row(ROW_ITEM, 3'd0,
            mk_cmd(pcs_pkg::OP_CLR_EDIT, 3'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1'b0), 1, 1'b0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_CFG) begin
        write_edit_pattern(row.cfg_val);
      end else begin
        for (int j = 0; j < int'(row.reps); j++) begin
          issue(row.cmd, row.typed, row.want);
          sender_gap(k % 4 == 0);
        end
      end
    end

    // random part: mostly chain fills and tick runs that cross pattern boundaries
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)      write_edit_pattern(3'd7);
      else if (ph == 1) write_edit_pattern(3'd0);
      else              write_edit_pattern(3'($urandom_range(0, 7)));
      quiet = (ph == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(0, 99);
        if (burst < 10) begin
          repeat ($urandom_range(4, 10)) begin
            cmd = random_cmd();
            cmd.opcode = pcs_pkg::OP_CHAIN;
            issue(cmd, 1'b0, none);
            sender_gap(quiet);
            sent++;
          end
        end else if (burst < 18) begin
          repeat ($urandom_range(14, 20)) begin
            cmd = random_cmd();
            cmd.opcode = pcs_pkg::OP_TICK;
            issue(cmd, 1'b0, none);
            sender_gap(quiet);
            sent++;
          end
        end else begin
          issue(random_cmd(), 1'b0, none);
          sender_gap(quiet);
          sent++;
        end
      end
    end

    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
